@@ sv/fdsc_pkg.sv @@
// Package for the Forth data stack core: opcodes, status codes, payload types.
// No dependencies; used by every module in sv/ except fdsc_divider.
package fdsc_pkg;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIVMOD = 5'd3,
        OP_DUP = 5'd4, OP_DROP = 5'd5, OP_SWAP = 5'd6, OP_OVER = 5'd7,
        OP_ROT = 5'd8, OP_2DUP = 5'd9, OP_2DROP = 5'd10, OP_2SWAP = 5'd11,
        OP_2OVER = 5'd12, OP_GT = 5'd13, OP_LT = 5'd14, OP_UGT = 5'd15,
        OP_ULT = 5'd16, OP_EQ = 5'd17, OP_NE = 5'd18, OP_FETCH = 5'd19,
        OP_STORE = 5'd20, OP_COMMA = 5'd21, OP_HERE = 5'd22, OP_LIT = 5'd23,
        OP_DOT = 5'd24, OP_EMIT = 5'd25,
        OP_NOP26 = 5'd26, OP_NOP27 = 5'd27, OP_NOP28 = 5'd28, OP_NOP29 = 5'd29,
        OP_NOP30 = 5'd30, OP_NOP31 = 5'd31
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd4;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_DOT  = 2'd1;
    localparam logic [1:0] PK_EMIT = 2'd2;

    localparam logic [31:0] CH_LOW  = 32'd32;  // ' '
    localparam logic [31:0] CH_HIGH = 32'd122; // 'z'

    typedef struct packed {
        logic [4:0]  op;
        logic [31:0] literal_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  print_kind;
        logic [31:0] print_value;
        logic [31:0] top_value;
        logic [5:0]  stack_depth;
    } out_word_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic       load_in;    // capture input word
        logic [2:0] rd_slot;    // which stack slot below top to read (0..3)
        logic       rd_en;      // issue stack read
        logic       div_start;
        logic       exec;       // check + commit
        logic       wr_en;      // stack write from write queue
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic more_writes;
        logic mem_clear;        // cell memory clearing pass after reset
    } sts_t;

endpackage

@@ sv/fdsc_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle, truncating signed.
// Depends on nothing outside this file.
module fdsc_divider #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic          nq_reg, nq_next, nr_reg, nr_next;
    logic [W:0]    trial;
    logic [W-1:0]  ma, mb;

    assign ma = dividend[W-1] ? (~dividend + 1'b1) : dividend;
    assign mb = divisor[W-1] ? (~divisor + 1'b1) : divisor;
    assign trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};

    always_comb begin
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        nq_next = nq_reg;
        nr_next = nr_reg;
        if (start) begin
            cnt_next = CW'(W);
            q_next = ma;
            r_next = '0;
            d_next = mb;
            nq_next = dividend[W-1] ^ divisor[W-1];
            nr_next = dividend[W-1];
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[W]) begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        nq_reg <= nq_next;
        nr_reg <= nr_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = nq_reg ? (~q_reg + 1'b1) : q_reg;
    assign rem  = nr_reg ? (~r_reg + 1'b1) : r_reg;
endmodule

@@ sv/fdsc_datapath.sv @@
// Datapath: stack memory, cell memory, operand registers, ALU, result register.
// Depends on fdsc_pkg and fdsc_divider.
module fdsc_datapath #(
    parameter int STACK_DEPTH = 32,
    parameter int CELL_BITS   = 32,
    parameter int MEM_CELLS   = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fdsc_pkg::cmd_t      cmd,
    output fdsc_pkg::sts_t      sts,
    input  fdsc_pkg::in_word_t  in_word,
    output fdsc_pkg::out_word_t out_word
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int MAW = $clog2(MEM_CELLS);
    localparam int HW  = $clog2(MEM_CELLS + 1);
    localparam int CW  = CELL_BITS;

    logic [CW-1:0] stack_mem [STACK_DEPTH];
    logic [CW-1:0] cell_mem  [MEM_CELLS];
    // clearing pass after reset zeroes one cell per cycle, the one at fill_reg
    logic [MAW:0]  fill_reg;
    logic          mem_clear;
    assign mem_clear = (fill_reg < (MAW+1)'(MEM_CELLS));

    logic [4:0]     op_reg;
    logic [CW-1:0]  lit_reg;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [HW-1:0]  here_reg;
    logic [CW-1:0]  opr_reg [4];   // d, c, b, a
    logic [CW-1:0]  rd_data_reg, mem_q_reg;
    logic [2:0]     rd_slot_q;
    logic           rd_v_reg;
    logic [CW-1:0]  top_reg;

    // write queue of up to four stack writes
    logic [SAW-1:0] wq_addr_reg [4];
    logic [CW-1:0]  wq_data_reg [4];
    logic [2:0]     wq_cnt_reg, wq_idx_reg;

    logic [2:0]     status_reg;
    logic [1:0]     kind_reg;
    logic [CW-1:0]  pval_reg;

    logic [CW-1:0]  quot, rem;
    logic           div_busy;

    fdsc_divider #(.W(CW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(opr_reg[1]), .divisor(opr_reg[0]),
        .busy(div_busy), .quot(quot), .rem(rem)
    );

    logic [SPW-1:0] rd_pos;
    assign rd_pos = sp_reg - SPW'(cmd.rd_slot) - 1'b1;

    // stack and memory reads, and queued stack writes
    always_ff @(posedge aclk) begin
        rd_data_reg <= stack_mem[rd_pos[SAW-1:0]];
        rd_slot_q <= cmd.rd_slot;
        mem_q_reg <= cell_mem[opr_reg[0][MAW-1:0]];
        if (cmd.wr_en)
            stack_mem[wq_addr_reg[wq_idx_reg[1:0]]] <= wq_data_reg[wq_idx_reg[1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) rd_v_reg <= 1'b0;
        else rd_v_reg <= cmd.rd_en;
        if (rd_v_reg) opr_reg[rd_slot_q[1:0]] <= rd_data_reg;
        if (cmd.load_in) begin
            op_reg <= in_word.op;
            lit_reg <= CW'(signed'(in_word.literal_value));
        end
    end

    // need / net per op
    logic [2:0] need;
    logic signed [2:0] net;
    always_comb begin
        need = 3'd0;
        net = 3'sd0;
        case (op_reg)
            fdsc_pkg::OP_ADD, fdsc_pkg::OP_SUB, fdsc_pkg::OP_MUL,
            fdsc_pkg::OP_GT, fdsc_pkg::OP_LT, fdsc_pkg::OP_UGT,
            fdsc_pkg::OP_ULT, fdsc_pkg::OP_EQ, fdsc_pkg::OP_NE: begin
                need = 3'd2; net = -3'sd1;
            end
            fdsc_pkg::OP_DIVMOD, fdsc_pkg::OP_SWAP: begin need = 3'd2; net = 3'sd0; end
            fdsc_pkg::OP_DUP: begin need = 3'd1; net = 3'sd1; end
            fdsc_pkg::OP_DROP, fdsc_pkg::OP_COMMA, fdsc_pkg::OP_DOT,
            fdsc_pkg::OP_EMIT: begin need = 3'd1; net = -3'sd1; end
            fdsc_pkg::OP_OVER: begin need = 3'd2; net = 3'sd1; end
            fdsc_pkg::OP_ROT: begin need = 3'd3; net = 3'sd0; end
            fdsc_pkg::OP_2DUP: begin need = 3'd2; net = 3'sd2; end
            fdsc_pkg::OP_2DROP, fdsc_pkg::OP_STORE: begin need = 3'd2; net = -3'sd2; end
            fdsc_pkg::OP_2SWAP: begin need = 3'd4; net = 3'sd0; end
            fdsc_pkg::OP_2OVER: begin need = 3'd4; net = 3'sd2; end
            fdsc_pkg::OP_FETCH: begin need = 3'd1; net = 3'sd0; end
            fdsc_pkg::OP_HERE, fdsc_pkg::OP_LIT: begin need = 3'd0; net = 3'sd1; end
            default: begin need = 3'd0; net = 3'sd0; end
        endcase
    end

    logic [CW-1:0] d, c, b, a, memv;
    logic [CW-1:0] sg;
    assign d = opr_reg[0];
    assign c = opr_reg[1];
    assign b = opr_reg[2];
    assign a = opr_reg[3];
    assign sg = {1'b1, {(CW-1){1'b0}}};
    assign memv = mem_q_reg;

    logic        addr_bad;
    assign addr_bad = ({1'b0, d} >= (CW+1)'(MEM_CELLS));

    logic [2:0] st;
    always_comb begin
        st = fdsc_pkg::ST_OK;
        if (op_reg <= fdsc_pkg::OP_EMIT) begin
            if (sp_reg < SPW'(need))
                st = fdsc_pkg::ST_UNDERFLOW;
            else if (net > 0 && ({1'b0, sp_reg} + (SPW+1)'(net)) > (SPW+1)'(STACK_DEPTH))
                st = fdsc_pkg::ST_OVERFLOW;
            else if (op_reg == fdsc_pkg::OP_DIVMOD && d == '0)
                st = fdsc_pkg::ST_DIV_ZERO;
            else if ((op_reg == fdsc_pkg::OP_FETCH || op_reg == fdsc_pkg::OP_STORE)
                     && addr_bad)
                st = fdsc_pkg::ST_BAD_ADDR;
            else if (op_reg == fdsc_pkg::OP_COMMA && here_reg >= HW'(MEM_CELLS))
                st = fdsc_pkg::ST_BAD_ADDR;
        end
    end

    // stack writes built at commit
    logic [CW-1:0]  wd [4];
    logic [SPW-1:0] wa [4];
    logic [2:0]     wn;
    logic [1:0]     kind;
    logic [CW-1:0]  pval;
    logic [CW-1:0]  prod;
    assign prod = c * d;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            wd[i] = '0;
            wa[i] = '0;
        end
        wn = 3'd0;
        kind = fdsc_pkg::PK_NONE;
        pval = '0;
        case (op_reg)
            fdsc_pkg::OP_ADD: begin wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = c + d; end
            fdsc_pkg::OP_SUB: begin wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = c - d; end
            fdsc_pkg::OP_MUL: begin wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = prod; end
            fdsc_pkg::OP_DIVMOD: begin
                wn = 3'd2; wa[0] = sp_reg - 2'd2; wd[0] = rem;
                wa[1] = sp_reg - 1'b1; wd[1] = quot;
            end
            fdsc_pkg::OP_DUP: begin wn = 3'd1; wa[0] = sp_reg; wd[0] = d; end
            fdsc_pkg::OP_SWAP: begin
                wn = 3'd2; wa[0] = sp_reg - 2'd2; wd[0] = d; wa[1] = sp_reg - 1'b1; wd[1] = c;
            end
            fdsc_pkg::OP_OVER: begin wn = 3'd1; wa[0] = sp_reg; wd[0] = c; end
            fdsc_pkg::OP_ROT: begin
                wn = 3'd3; wa[0] = sp_reg - 2'd3; wd[0] = c;
                wa[1] = sp_reg - 2'd2; wd[1] = d; wa[2] = sp_reg - 1'b1; wd[2] = b;
            end
            fdsc_pkg::OP_2DUP: begin
                wn = 3'd2; wa[0] = sp_reg; wd[0] = c; wa[1] = sp_reg + 1'b1; wd[1] = d;
            end
            fdsc_pkg::OP_2SWAP: begin
                wn = 3'd4; wa[0] = sp_reg - 3'd4; wd[0] = c; wa[1] = sp_reg - 2'd3; wd[1] = d;
                wa[2] = sp_reg - 2'd2; wd[2] = a; wa[3] = sp_reg - 1'b1; wd[3] = b;
            end
            fdsc_pkg::OP_2OVER: begin
                wn = 3'd2; wa[0] = sp_reg; wd[0] = a; wa[1] = sp_reg + 1'b1; wd[1] = b;
            end
            fdsc_pkg::OP_GT: begin
                wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = CW'((c ^ sg) > (d ^ sg));
            end
            fdsc_pkg::OP_LT: begin
                wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = CW'((c ^ sg) < (d ^ sg));
            end
            fdsc_pkg::OP_UGT: begin wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = CW'(c > d); end
            fdsc_pkg::OP_ULT: begin wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = CW'(c < d); end
            fdsc_pkg::OP_EQ: begin wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = CW'(c == d); end
            fdsc_pkg::OP_NE: begin wn = 3'd1; wa[0] = sp_reg - 2'd2; wd[0] = CW'(c != d); end
            fdsc_pkg::OP_FETCH: begin wn = 3'd1; wa[0] = sp_reg - 1'b1; wd[0] = memv; end
            fdsc_pkg::OP_HERE: begin wn = 3'd1; wa[0] = sp_reg; wd[0] = CW'(here_reg); end
            fdsc_pkg::OP_LIT: begin wn = 3'd1; wa[0] = sp_reg; wd[0] = lit_reg; end
            fdsc_pkg::OP_DOT: begin kind = fdsc_pkg::PK_DOT; pval = d; end
            fdsc_pkg::OP_EMIT: begin
                if (d >= CW'(fdsc_pkg::CH_LOW) && d <= CW'(fdsc_pkg::CH_HIGH)) begin
                    kind = fdsc_pkg::PK_EMIT; pval = d;
                end
            end
            default: wn = 3'd0;
        endcase
    end

    logic commit;
    assign commit = cmd.exec && st == fdsc_pkg::ST_OK && op_reg <= fdsc_pkg::OP_EMIT;
    assign sp_next = sp_reg + SPW'(signed'(net));

    logic [MAW-1:0] mem_waddr;
    logic           mem_we;
    assign mem_we = commit && (op_reg == fdsc_pkg::OP_STORE || op_reg == fdsc_pkg::OP_COMMA);
    assign mem_waddr = (op_reg == fdsc_pkg::OP_STORE) ? d[MAW-1:0] : here_reg[MAW-1:0];

    // input is held off during the clearing pass, so the two writes never meet
    always_ff @(posedge aclk) begin
        if (mem_clear) begin
            cell_mem[fill_reg[MAW-1:0]] <= '0;
        end else if (mem_we) begin
            cell_mem[mem_waddr] <= (op_reg == fdsc_pkg::OP_STORE) ? c : d;
        end
    end

    // the top after the step: last queued write if it lands on the new top,
    // otherwise a surviving operand
    logic [CW-1:0] top_calc;
    always_comb begin
        top_calc = '0;
        for (int i = 0; i < 4; i++)
            if (sp_next == sp_reg - SPW'(i)) top_calc = opr_reg[i];
        for (int i = 0; i < 4; i++)
            if (3'(i) < wn && wa[i] == sp_next - 1'b1) top_calc = wd[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
            here_reg <= '0;
            fill_reg <= '0;
            wq_cnt_reg <= '0;
            wq_idx_reg <= '0;
            top_reg <= '0;
        end else begin
            if (commit) begin
                sp_reg <= sp_next;
                top_reg <= (sp_next == '0) ? '0 : top_calc;
                wq_cnt_reg <= wn;
                wq_idx_reg <= '0;
                if (op_reg == fdsc_pkg::OP_COMMA) here_reg <= here_reg + 1'b1;
            end else if (cmd.wr_en) begin
                wq_idx_reg <= wq_idx_reg + 1'b1;
            end
            if (mem_clear) fill_reg <= fill_reg + 1'b1;
        end
        if (commit) begin
            for (int i = 0; i < 4; i++) begin
                wq_addr_reg[i] <= wa[i][SAW-1:0];
                wq_data_reg[i] <= wd[i];
            end
        end
        if (cmd.exec) begin
            status_reg <= st;
            kind_reg <= commit ? kind : fdsc_pkg::PK_NONE;
            pval_reg <= commit ? pval : '0;
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.more_writes = (wq_idx_reg < wq_cnt_reg);
    assign sts.mem_clear = mem_clear;

    always_comb begin
        out_word.status = status_reg;
        out_word.print_kind = kind_reg;
        out_word.print_value = 32'(pval_reg);
        out_word.top_value = 32'(top_reg);
        out_word.stack_depth = 6'(sp_reg);
    end
endmodule

@@ sv/fdsc_ctrl.sv @@
// Controller state machine: operand fetch, divide wait, commit, write-back, output.
// Depends on fdsc_pkg.
module fdsc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  fdsc_pkg::sts_t      sts,
    output fdsc_pkg::cmd_t      cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_RD   = 7'b0000010, S_DIV  = 7'b0000100,
        S_WAIT = 7'b0001000, S_EXEC = 7'b0010000, S_WB   = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] slot_reg, slot_next;
    logic       mv_reg, mv_next;

    always_comb begin
        state_next = state_reg;
        slot_next = slot_reg;
        mv_next = mv_reg;
        cmd = '0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        s_ready = (state_reg == S_IDLE) && !sts.mem_clear;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_in = 1'b1;
                    slot_next = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                // read four slots below top; S_WAIT then waits out the registered read path
                cmd.rd_en = 1'b1;
                cmd.rd_slot = slot_reg;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == 3'd3) begin
                    slot_next = '0;
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == 3'd1) begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!sts.div_busy) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (!mv_reg || m_ready) begin
                    cmd.exec = 1'b1;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                if (sts.more_writes) cmd.wr_en = 1'b1;
                else state_next = S_OUT;
            end
            S_OUT: begin
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            slot_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            mv_reg <= mv_next;
        end
    end

    assign m_valid = mv_reg;
endmodule

@@ sv/forth_data_stack_core.sv @@
// Forth data stack core: executes one primitive per input word on a data stack
// and a cell memory, returning one result word with status, print and stack view.
// Words are handled one at a time. After a word is accepted, the core does four
// operand reads on the single stack read port, waits out the read latency, runs
// the divider (which runs on every word), commits, writes back the op's stack
// writes (0..4) and presents the result. The next word is taken as the result
// goes valid; commit waits while the previous result is still waiting. After
// reset the cell memory is cleared one cell per cycle; s_ready stays low until
// the clearing pass is done.
module forth_data_stack_core #(
    parameter int STACK_DEPTH = 32,
    parameter int CELL_BITS   = 32,
    parameter int MEM_CELLS   = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fdsc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fdsc_pkg::out_word_t m_data
);
    fdsc_pkg::cmd_t cmd;
    fdsc_pkg::sts_t sts;

    fdsc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    fdsc_datapath #(
        .STACK_DEPTH(STACK_DEPTH), .CELL_BITS(CELL_BITS), .MEM_CELLS(MEM_CELLS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_word(s_data), .out_word(m_data)
    );
endmodule
